/* rtl/itf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Shared types, constants and the digit-to-character function.
// ----------------------------------------------------------------------------
package itf_pkg;

    // Width of the value field on the input channel.
    localparam int DATA_W    = 32;
    // Width of the mode field on the input channel.
    localparam int CMD_W     = 2;
    // Width of one output character.
    localparam int CHAR_W    = 8;
    // Decimal digits held for one value, and the width of one digit.
    localparam int N_DIG     = 10;
    localparam int DIG_W     = 4;
    localparam int BCD_W     = N_DIG * DIG_W;
    // Width of a digit count or digit position (holds up to N_DIG).
    localparam int CNT_W     = 4;
    // Double-dabble steps per pipeline stage, and the number of stages.
    localparam int DD_STEPS  = 4;
    localparam int DD_STAGES = DATA_W / DD_STEPS;
    // Hex digits in one value.
    localparam int N_HEX     = DATA_W / DIG_W;

    // ASCII characters used by the formatter.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_TEN   = 8'd10;

    // Conversion modes.
    typedef enum logic [CMD_W-1:0] {
        MODE_SDEC = 2'd0,
        MODE_UDEC = 2'd1,
        MODE_HEXL = 2'd2,
        MODE_HEXU = 2'd3
    } t_mode;

    // Payload of one item inside the conversion pipeline.
    typedef struct packed {
        t_mode              mode;
        logic               neg;
        logic [DATA_W-1:0]  bin;
        logic [DATA_W-1:0]  hexv;
        logic [BCD_W-1:0]   bcd;
    } t_item;

    // Formatted text handed to the serialiser.
    typedef struct packed {
        logic                          neg;
        logic                          upper;
        logic [N_DIG-1:0][DIG_W-1:0]   dig;
        logic [CNT_W-1:0]              cnt;
    } t_text;

    // Turns one digit value into its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIG_W){1'b0}}, d};
        if (d_ext < CH_TEN) begin
            return CH_ZERO + d_ext;
        end
        return (upper ? CH_UP_A : CH_LOW_A) + d_ext - CH_TEN;
    endfunction

endpackage

/* rtl/itf_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter input channel
// Valid/ready channel carrying the conversion mode and the raw value.
// ----------------------------------------------------------------------------
interface itf_in_if;

    logic                          valid;
    logic                          ready;
    logic [itf_pkg::CMD_W-1:0]     cmd;
    logic [itf_pkg::DATA_W-1:0]    value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);

endinterface

/* rtl/itf_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter output channel
// Valid/ready channel carrying one text character and its last flag.
// ----------------------------------------------------------------------------
interface itf_out_if;

    logic                          valid;
    logic                          ready;
    logic [itf_pkg::CHAR_W-1:0]    char_out;
    logic                          last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);

endinterface

/* rtl/integer_to_text_formatter.sv */
`timescale 1ns / 1ps
// A value leaves as 1 to 11 characters, one per transfer; the single-character output
// channel sets the pace, and the pipeline stalls behind it.
// The conversion pipeline is an input stage, eight double-dabble stages and a format stage.
// Reset (synchronous, active low) clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// Integer to text formatter
// Converts a value to signed or unsigned decimal or hex ASCII text.
// ----------------------------------------------------------------------------
module integer_to_text_formatter #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    itf_in_if.sink   i_in,
    itf_out_if.source o_out
);
    import itf_pkg::*;

    // Bits of the value that take part, and whether a sign can exist.
    localparam int EFF_W = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
    localparam logic SIGNED_OK = (VALUE_WIDTH <= DATA_W);
    localparam logic [DATA_W:0] MASK_X = ({{DATA_W{1'b0}}, 1'b1} << EFF_W) - 1'b1;
    localparam logic [DATA_W-1:0] MASK = MASK_X[DATA_W-1:0];

    logic  adv;
    logic  ser_take;

    logic  r_v0;
    t_item r_item0;
    t_item n_item0;

    logic  w_val  [DD_STAGES+1];
    t_item w_item [DD_STAGES+1];

    logic  r_fmt_valid;
    t_text r_fmt;
    t_text n_fmt;

    logic [DATA_W-1:0] v_m;
    logic              v_neg;

    // The whole pipeline moves when the format stage is empty or handing over.
    assign adv        = !r_fmt_valid || ser_take;
    assign i_in.ready = adv;

    // Input stage: mask to width, detect the sign and form the magnitude.
    always_comb begin
        v_m   = i_in.value & MASK;
        v_neg = SIGNED_OK && (t_mode'(i_in.cmd) == MODE_SDEC) && v_m[EFF_W-1];
        n_item0.mode = t_mode'(i_in.cmd);
        n_item0.neg  = v_neg;
        n_item0.bin  = v_neg ? ((~v_m + 1'b1) & MASK) : v_m;
        n_item0.hexv = v_m;
        n_item0.bcd  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_item0 <= n_item0;
        end
    end

    // Double-dabble stages.
    assign w_val[0]  = r_v0;
    assign w_item[0] = r_item0;

    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        itf_dabble u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (w_val[g]),
            .i_item  (w_item[g]),
            .o_valid (w_val[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Format stage: pick decimal or hex digits and count the significant ones.
    always_comb begin
        t_item it;
        logic  hex;
        it  = w_item[DD_STAGES];
        hex = (it.mode == MODE_HEXL) || (it.mode == MODE_HEXU);
        n_fmt.neg   = it.neg;
        n_fmt.upper = (it.mode == MODE_HEXU);
        for (int d = 0; d < N_DIG; d++) begin
            if (hex) begin
                n_fmt.dig[d] = (d < N_HEX) ? it.hexv[(d % N_HEX)*DIG_W +: DIG_W] : '0;
            end else begin
                n_fmt.dig[d] = it.bcd[d*DIG_W +: DIG_W];
            end
        end
        n_fmt.cnt = 4'd1;
        for (int d = 1; d < N_DIG; d++) begin
            if (n_fmt.dig[d] != '0) begin
                n_fmt.cnt = CNT_W'(d + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_valid <= 1'b0;
        end else if (adv) begin
            r_fmt_valid <= w_val[DD_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fmt <= n_fmt;
        end
    end

    // Character serialiser and output register.
    itf_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fmt_valid),
        .i_text  (r_fmt),
        .o_take  (ser_take),
        .o_out   (o_out)
    );

    // The pipeline only stalls while a formatted value waits for the serialiser.
    a_stall_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> r_fmt_valid)
        else $error("pipeline stalled with an empty format stage");

    // A value handed to the serialiser has between one and ten digits.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fmt_valid && ser_take) |-> (r_fmt.cnt >= 4'd1 && r_fmt.cnt <= 4'd10))
        else $error("digit count out of range");

    // The final character of a text is never the minus sign.
    a_last_not_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.char_out != CH_MINUS))
        else $error("text ended on a minus sign");

endmodule

/* rtl/itf_dabble.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-dabble pipeline stage
// Runs a fixed number of shift-and-add-three steps and registers the result.
// ----------------------------------------------------------------------------
module itf_dabble (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  itf_pkg::t_item i_item,
    output logic           o_valid,
    output itf_pkg::t_item o_item
);
    import itf_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Shift-and-add-three steps; each digit is corrected on its own.
    always_comb begin
        n_item = i_item;
        for (int s = 0; s < DD_STEPS; s++) begin
            for (int d = 0; d < N_DIG; d++) begin
                if (n_item.bcd[d*DIG_W +: DIG_W] >= 4'd5) begin
                    n_item.bcd[d*DIG_W +: DIG_W] = n_item.bcd[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            n_item.bcd = {n_item.bcd[BCD_W-2:0], n_item.bin[DATA_W-1]};
            n_item.bin = {n_item.bin[DATA_W-2:0], 1'b0};
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/itf_serial.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text serialiser
// Emits the sign and digits of one value, one character per transfer.
// ----------------------------------------------------------------------------
module itf_serial (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  itf_pkg::t_text i_text,
    output logic           o_take,
    itf_out_if.source      o_out
);
    import itf_pkg::*;

    logic                           r_busy;
    logic                           r_sgn;
    logic                           r_upper;
    logic [CNT_W-1:0]               r_pos;
    logic [N_DIG-1:0][DIG_W-1:0]    r_dig;
    logic                           r_ov;
    logic [CHAR_W-1:0]              r_char;
    logic                           r_last;

    logic out_free;
    logic emit;
    logic finish;
    logic load;

    // The output register is free when empty or being transferred now.
    assign out_free = !r_ov || o_out.ready;
    assign emit     = r_busy && out_free;
    assign finish   = emit && !r_sgn && (r_pos == '0);
    assign load     = i_valid && (!r_busy || finish);
    assign o_take   = !r_busy || finish;

    // Control state of the character walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Digit store, position and the pending sign.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dig   <= i_text.dig;
            r_upper <= i_text.upper;
            r_sgn   <= i_text.neg;
            r_pos   <= i_text.cnt - 4'd1;
        end else if (emit) begin
            if (r_sgn) begin
                r_sgn <= 1'b0;
            end else if (r_pos != '0) begin
                r_pos <= r_pos - 4'd1;
            end
        end
    end

    // Output register: the sign first, then digits most significant first.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_sgn) begin
                r_char <= CH_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= digit_char(r_dig[r_pos], r_upper);
                r_last <= (r_pos == '0);
            end
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.char_out = r_char;
    assign o_out.last     = r_last;

endmodule
